// ===== rtl/fbpa_pkg.sv =====
// Shared types and constants for the fixed block pool allocator.
// No dependencies; every file but fbpa_ram imports this package.
package fbpa_pkg;

  localparam int MAX_CELLS = 1024;
  localparam int ADDR_BITS = 32;
  localparam int SIZE_W    = 17;
  localparam int CNT_W     = 11;
  localparam int PTR_W     = $clog2(MAX_CELLS);
  localparam int OCC_W     = $clog2(MAX_CELLS + 1);
  localparam int SUM_W     = ((OCC_W > CNT_W) ? OCC_W : CNT_W) + 1;
  localparam int PROD_W    = CNT_W + SIZE_W;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 32;

  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [SIZE_W-1:0]    size_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [OCC_W-1:0]     occ_t;
  typedef logic [SUM_W-1:0]     sum_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_BASE  = 2'd0,
    CFG_CELL_SIZE  = 2'd1,
    CFG_CELL_COUNT = 2'd2
  } cfg_idx_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_EMPTY    = 2'd1,
    STAT_OVERFLOW = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_FETCH
  } state_e;

  typedef struct packed {
    logic  req_type;
    addr_t block_addr;
  } in_t;

  typedef struct packed {
    status_e status;
    addr_t   alloc_addr;
    cnt_t    free_blocks;
  } out_t;

  // Configuration view handed from the register block to the core.
  typedef struct packed {
    logic  busy;
    logic  apply;
    addr_t carve_start;
    cnt_t  cell_count;
    size_t blk_size;
  } cfg_t;

endpackage

// ===== rtl/fbpa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
// No dependencies.
module fbpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fbpa_cfg.sv =====
// Configuration registers and the pool reinitialization pipeline.
// Depends on fbpa_pkg.
module fbpa_cfg
  import fbpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i,
  output cfg_t                 cfg_o
);

  addr_t             pool_base_q, pool_base_d;
  size_t             blk_size_q, blk_size_d;
  cnt_t              cell_count_q, cell_count_d;
  logic [PROD_W-1:0] product_q;
  addr_t             start_q;
  logic [2:0]        pend_q, pend_d;
  logic              hit;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    pool_base_d  = pool_base_q;
    blk_size_d   = blk_size_q;
    cell_count_d = cell_count_q;
    hit          = 1'b0;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_POOL_BASE: begin
          pool_base_d = ADDR_BITS'(cfg_data_i);
          hit         = 1'b1;
        end
        CFG_CELL_SIZE: begin
          blk_size_d = cfg_data_i[SIZE_W-1:0];
          hit        = 1'b1;
        end
        CFG_CELL_COUNT: begin
          cell_count_d = cfg_data_i[CNT_W-1:0];
          hit          = 1'b1;
        end
        default: hit = 1'b0;
      endcase
    end
    // Restart the product/sum pipeline on every valid write to a mapped register.
    pend_d = {pend_q[1:0], hit};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_base_q  <= '0;
      blk_size_q   <= SIZE_W'(8);
      cell_count_q <= '0;
      pend_q       <= '0;
    end else begin
      pool_base_q  <= pool_base_d;
      blk_size_q   <= blk_size_d;
      cell_count_q <= cell_count_d;
      pend_q       <= pend_d;
    end
  end

  // Top of the pool: base + count * size, multiply and add in separate stages.
  always_ff @(posedge clk_i) begin
    product_q <= PROD_W'(cell_count_q) * PROD_W'(blk_size_q);
    start_q   <= pool_base_q + ADDR_BITS'(product_q);
  end

  assign cfg_o.busy        = |pend_q;
  assign cfg_o.apply       = pend_q[2];
  assign cfg_o.carve_start = start_q;
  assign cfg_o.cell_count  = cell_count_q;
  assign cfg_o.blk_size    = blk_size_q;

endmodule

// ===== rtl/fbpa_core.sv =====
// Allocator core: free-list FIFO in RAM, carve pointer, counters, result register.
// Depends on fbpa_pkg and fbpa_ram.
module fbpa_core
  import fbpa_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_o
);

  state_e state_q, state_d;
  ptr_t   head_q, head_d;
  ptr_t   tail_q, tail_d;
  occ_t   occ_q, occ_d;
  cnt_t   rem_q, rem_d;
  addr_t  carve_q, carve_d;
  logic   out_valid_q, out_valid_d;
  out_t   out_q, out_d;

  logic   in_fire;
  logic   take_fifo;
  logic   ram_we, ram_re;
  addr_t  ram_rdata;
  sum_t   total_cur;
  sum_t   total_nxt;

  function automatic ptr_t next_ptr(ptr_t p);
    return (p == PTR_W'(MAX_CELLS - 1)) ? '0 : p + 1'b1;
  endfunction

  assign in_ready_o = (state_q == S_IDLE) && !cfg_i.busy && (!out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i && in_ready_o;
  assign take_fifo  = in_fire && (in_i.req_type == REQ_ALLOC) && (occ_q != '0);
  assign total_cur  = sum_t'(occ_q) + sum_t'(rem_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (take_fifo) state_d = S_FETCH;
      S_FETCH: state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    occ_d       = occ_q;
    rem_d       = rem_q;
    carve_d     = carve_q;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cfg_i.apply) begin
      head_d  = '0;
      tail_d  = '0;
      occ_d   = '0;
      rem_d   = cfg_i.cell_count;
      carve_d = cfg_i.carve_start;
    end else if (state_q == S_FETCH) begin
      out_d.status     = STAT_OK;
      out_d.alloc_addr = ram_rdata;
      out_valid_d      = 1'b1;
    end else if (in_fire) begin
      out_d.status     = STAT_OK;
      out_d.alloc_addr = '0;
      if (in_i.req_type == REQ_ALLOC) begin
        if (occ_q != '0) begin
          // Oldest freed block; data returns next cycle.
          ram_re = 1'b1;
          head_d = next_ptr(head_q);
          occ_d  = occ_q - 1'b1;
        end else if (rem_q != '0) begin
          carve_d          = carve_q - ADDR_BITS'(cfg_i.blk_size);
          rem_d            = rem_q - 1'b1;
          out_d.alloc_addr = carve_d;
          out_valid_d      = 1'b1;
        end else begin
          out_d.status = STAT_EMPTY;
          out_valid_d  = 1'b1;
        end
      end else begin
        if (total_cur >= sum_t'(cfg_i.cell_count) || occ_q == OCC_W'(MAX_CELLS)) begin
          out_d.status = STAT_OVERFLOW;
        end else begin
          ram_we = 1'b1;
          tail_d = next_ptr(tail_q);
          occ_d  = occ_q + 1'b1;
        end
        out_valid_d = 1'b1;
      end
    end

    total_nxt         = sum_t'(occ_d) + sum_t'(rem_d);
    out_d.free_blocks = (out_valid_d && !(out_valid_q && !out_ready_i))
                        ? CNT_W'(total_nxt) : out_q.free_blocks;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      tail_q      <= '0;
      occ_q       <= '0;
      rem_q       <= '0;
      carve_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      occ_q       <= occ_d;
      rem_q       <= rem_d;
      carve_q     <= carve_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  fbpa_ram #(
    .WIDTH (ADDR_BITS),
    .DEPTH (MAX_CELLS)
  ) u_free_fifo (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (tail_q),
    .wdata_i (in_i.block_addr),
    .re_i    (ram_re),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  a_fetch_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FETCH |=> state_q == S_IDLE && out_valid_q)
    else $error("free-list read did not complete in one cycle");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    occ_q <= OCC_W'(MAX_CELLS))
    else $error("free-list occupancy exceeds capacity");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> !(out_valid_q && !out_ready_i))
    else $error("item accepted while result register is held");

  a_ram_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ram_we && ram_re))
    else $error("free-list read and write in the same cycle");

  a_no_accept_in_init: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_i.apply |-> !in_fire && state_q == S_IDLE)
    else $error("item accepted during pool reinitialization");

endmodule

// ===== rtl/fixed_block_pool_allocator.sv =====
// Fixed block pool allocator: one result item per request item. A free, a carve
// allocation or an empty reply goes straight to the result register; an allocation from
// the free list first takes the registered read of the free-list RAM. Throughput: one
// item per cycle while no result is held by back-pressure; a free-list allocation holds off
// the next item until its read returns, and a register write holds off request items
// during multiply, add and load. Reset: empty pool, block size 8, RAM contents not cleared.
module fixed_block_pool_allocator
  import fbpa_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_DAT_W-1:0] cfg_data_i
);

  cfg_t cfg;

  fbpa_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  fbpa_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_i        (in_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_o       (out_o)
  );

endmodule

// ===== tb/fixed_block_pool_allocator_tb.sv =====
// Self-checking testbench for the fixed block pool allocator.
// Depends on fbpa_pkg and fixed_block_pool_allocator; a built-in pool predictor checks every result.
module fixed_block_pool_allocator_tb;
  import fbpa_pkg::*;

  localparam int CLK_PERIOD     = 8;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 4;
  localparam int RAND_PHASES    = 12;
  localparam int PHASE_ITEMS    = 80;
  localparam int FILL_CELLS     = 160;
  localparam int TIMEOUT_CYCLES = 250000;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 req_valid   = 1'b0;
  in_t                  req_item    = '0;
  logic                 out_ready   = 1'b0;
  logic                 cfg_valid   = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_DAT_W-1:0] cfg_data    = '0;
  logic                 steady      = 1'b0;
  logic                 in_ready;
  logic                 out_valid;
  logic                 cfg_ready;
  out_t                 out_item;

  // Pool predictor state, starting from the reset values
  addr_t base_q     = '0;
  size_t size_q     = SIZE_W'(8);
  cnt_t  count_q    = '0;
  addr_t ring [MAX_CELLS];
  int    head       = 0;
  int    tail       = 0;
  int    queued     = 0;
  addr_t carve_ptr  = '0;
  int    carve_left = 0;

  out_t  replies_due [$];
  addr_t granted [$];
  int    errors   = 0;
  int    n_reqs   = 0;
  int    n_writes = 0;

  fixed_block_pool_allocator dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (req_valid),
    .in_ready_o  (in_ready),
    .in_i        (req_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_o       (out_item),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= 20);
  end

  function automatic void reinit_pool();
    head       = 0;
    tail       = 0;
    queued     = 0;
    carve_ptr  = base_q + count_q * size_q;
    carve_left = count_q;
    granted.delete();
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    case (idx)
      CFG_POOL_BASE:  base_q  = data;
      CFG_CELL_SIZE:  size_q  = data[SIZE_W-1:0];
      CFG_CELL_COUNT: count_q = data[CNT_W-1:0];
      default:        return;  // unmapped index: keep the pool as it is
    endcase
    reinit_pool();
  endfunction

  function automatic out_t serve_request(in_t req);
    out_t r;
    r = '0;
    r.status = STAT_OK;
    if (req.req_type == REQ_ALLOC) begin
      if (queued > 0) begin
        r.alloc_addr = ring[head];
        head = (head + 1) % MAX_CELLS;
        queued--;
      end else if (carve_left > 0) begin
        carve_ptr = carve_ptr - size_q;
        carve_left--;
        r.alloc_addr = carve_ptr;
      end else begin
        r.status = STAT_EMPTY;
      end
      if (r.status == STAT_OK) granted.push_back(r.alloc_addr);
    end else if (queued + carve_left >= int'(count_q) || queued >= MAX_CELLS) begin
      r.status = STAT_OVERFLOW;
    end else begin
      ring[tail] = req.block_addr;
      tail = (tail + 1) % MAX_CELLS;
      queued++;
    end
    r.free_blocks = cnt_t'(queued + carve_left);
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) begin
        apply_reg(cfg_index, cfg_data);
        n_writes++;
      end
      if (req_valid && in_ready) begin
        replies_due.push_back(serve_request(req_item));
        n_reqs++;
      end
      if (out_valid && out_ready) begin
        if (replies_due.size() == 0) begin
          $error("result item with no request outstanding");
          errors++;
        end else begin
          want = replies_due.pop_front();
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            errors++;
          end
          if (out_item.alloc_addr !== want.alloc_addr) begin
            $error("alloc_addr: expected %h, got %h", want.alloc_addr, out_item.alloc_addr);
            errors++;
          end
          if (out_item.free_blocks !== want.free_blocks) begin
            $error("free_blocks: expected %0d, got %0d", want.free_blocks, out_item.free_blocks);
            errors++;
          end
        end
      end
    end
  end

  // Drop the request valid, drain outstanding results, then let the block settle.
  task automatic wait_idle();
    req_valid <= 1'b0;
    @(posedge clk);
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] data);
    wait_idle();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Hold valid across back-to-back items; lower it only for an idle gap.
  task automatic send_req(req_e kind, addr_t addr);
    in_t item;
    item.req_type   = kind;
    item.block_addr = addr;
    if (!steady) begin
      while ($urandom_range(0, 99) < 20) begin
        req_valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_valid <= 1'b1;
    req_item  <= item;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic test_empty_pool();
    send_req(REQ_ALLOC, 32'hFFFF_FFFF);
    send_req(REQ_FREE, 32'h0000_1234);
  endtask

  task automatic test_pool_basics();
    write_reg(CFG_POOL_BASE, 32'h0000_1000);
    write_reg(CFG_CELL_SIZE, 32'd16);
    write_reg(CFG_CELL_COUNT, 32'd3);
    repeat (4) send_req(REQ_ALLOC, 32'h0);
    send_req(REQ_FREE, 32'hFFFF_FFFF);
    send_req(REQ_FREE, 32'h0000_0000);
    send_req(REQ_FREE, 32'h0000_1010);
    send_req(REQ_FREE, 32'h0000_1020);
    repeat (4) send_req(REQ_ALLOC, 32'hA5A5_A5A5);
    // free straight into an allocate of the same entry
    send_req(REQ_FREE, 32'h5A5A_5A5A);
    send_req(REQ_ALLOC, 32'h0);
  endtask

  task automatic test_odd_settings();
    write_reg(CFG_POOL_BASE, 32'hFFFF_FFF8);
    write_reg(CFG_CELL_SIZE, 32'hFFFF_FFFF);
    write_reg(CFG_CELL_COUNT, 32'hFFFF_FFFF);
    repeat (2) send_req(REQ_ALLOC, 32'h0);
    write_reg(CFG_SPARE, $urandom);
    send_req(REQ_ALLOC, 32'h0);
    write_reg(CFG_CELL_SIZE, 32'd0);
    write_reg(CFG_CELL_COUNT, 32'd2);
    repeat (3) send_req(REQ_ALLOC, 32'h0);
    write_reg(CFG_POOL_BASE, 32'h0);
    write_reg(CFG_CELL_SIZE, 32'd65536);
    write_reg(CFG_CELL_COUNT, CFG_DAT_W'(MAX_CELLS));
    send_req(REQ_ALLOC, 32'h0);
  endtask

  // Carve the whole pool, queue every block on the free list, overflow it, drain it.
  task automatic test_full_free_list();
    write_reg(CFG_CELL_SIZE, 32'd8);
    write_reg(CFG_CELL_COUNT, CFG_DAT_W'(FILL_CELLS));
    write_reg(CFG_POOL_BASE, $urandom);
    steady <= 1'b1;
    repeat (FILL_CELLS + 1) send_req(REQ_ALLOC, $urandom);
    repeat (FILL_CELLS + 1) send_req(REQ_FREE, $urandom);
    steady <= 1'b0;
    repeat (FILL_CELLS + 1) send_req(REQ_ALLOC, $urandom);
  endtask

  task automatic choose_setting();
    logic [CFG_DAT_W-1:0] size_v;
    logic [CFG_DAT_W-1:0] count_v;
    case ($urandom_range(0, 9))
      0:       size_v = 0;
      1:       size_v = $urandom;
      2:       size_v = 65536;
      default: size_v = $urandom_range(8, 65536);
    endcase
    case ($urandom_range(0, 9))
      7:       count_v = $urandom_range(25, MAX_CELLS);
      8:       count_v = $urandom_range(0, 1) ? MAX_CELLS : 0;
      9:       count_v = $urandom;
      default: count_v = $urandom_range(1, 24);
    endcase
    if ($urandom_range(0, 3) != 0) write_reg(CFG_POOL_BASE, $urandom);
    write_reg(CFG_CELL_SIZE, size_v);
    write_reg(CFG_CELL_COUNT, count_v);
    if ($urandom_range(0, 4) == 0) write_reg(CFG_SPARE, $urandom);
  endtask

  task automatic test_random_traffic();
    int    lean;
    int    pick;
    addr_t victim;
    for (int phase = 0; phase < RAND_PHASES; phase++) begin
      choose_setting();
      steady <= (phase == RAND_PHASES / 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // swing between filling and draining so the pool hits both ends
        lean = ((k / 30) % 2) ? 30 : 70;
        if ($urandom_range(0, 99) < lean) begin
          send_req(REQ_ALLOC, $urandom);
        end else if (granted.size() != 0 && $urandom_range(0, 9) != 0) begin
          pick   = $urandom_range(0, granted.size() - 1);
          victim = granted[pick];
          granted.delete(pick);
          send_req(REQ_FREE, victim);
        end else begin
          send_req(REQ_FREE, $urandom);
        end
      end
    end
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_pool();
    test_pool_basics();
    test_odd_settings();
    test_full_free_list();
    test_random_traffic();
    wait_idle();
    $display("Checked %0d requests over %0d register writes: carving, free-list reuse,",
             n_reqs, n_writes);
    $display("empty and overflow replies, a pool-sized free list and wrapped addresses.");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_CYCLES * CLK_PERIOD);
    $display("Timed out with %0d results outstanding", replies_due.size());
    $display("Regression FAIL");
    $finish;
  end

endmodule
